### design/escape_count_cosine_colorizer_core_macros.svh
// ---------------------------------------------------------------------------
// escape count cosine colorizer assertion macros
// shared concurrent assertion forms, clocked on clock and quiet in reset
// ---------------------------------------------------------------------------
`ifndef ESCAPE_COUNT_COSINE_COLORIZER_CORE_MACROS_SVH
`define ESCAPE_COUNT_COSINE_COLORIZER_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define ECC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ECC_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ECC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ecc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ecc_pkg
// types, constants and table functions of the escape count cosine colorizer
// ---------------------------------------------------------------------------
package ecc_pkg;

   localparam int MAX_ITER        = 1000;
   localparam int COS_TABLE_DEPTH = 1024;

   localparam int ITER_W       = 18;
   localparam int NUM_SAMPLES  = 4;
   localparam int NUM_CHANNELS = 3;
   localparam int SUM_W        = ITER_W + 2;
   localparam int CNT_W        = 3;
   localparam int PHASE_W      = 16;
   localparam int COLOR_W      = 8;
   localparam int COS_W        = 16;

   // phase divide: numerator is sum with 8 extra fraction bits
   localparam int NUM_W        = SUM_W + 8;
   localparam int DIV_SHIFT    = NUM_W;
   localparam int SAMPLE_SCALE = 50;
   localparam int QUO_W        = 23;
   localparam int DIVISOR_W    = 8;
   localparam logic [QUO_W-1:0] RECIP_BY_1 = QUO_W'((64'd1 << DIV_SHIFT) / (SAMPLE_SCALE * 1));
   localparam logic [QUO_W-1:0] RECIP_BY_2 = QUO_W'((64'd1 << DIV_SHIFT) / (SAMPLE_SCALE * 2));
   localparam logic [QUO_W-1:0] RECIP_BY_3 = QUO_W'((64'd1 << DIV_SHIFT) / (SAMPLE_SCALE * 3));
   localparam logic [QUO_W-1:0] RECIP_BY_4 = QUO_W'((64'd1 << DIV_SHIFT) / (SAMPLE_SCALE * 4));

   localparam int MERGE_LATENCY = 4;
   localparam int LANE_LATENCY  = 3;
   localparam int PIPE_LATENCY  = MERGE_LATENCY + LANE_LATENCY;

   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_SELECT     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUPERSAMPLE_ENABLE = 1'b1;

   // color channel indexes
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // palette phase offsets in 1/65536 turn
   localparam logic [PHASE_W-1:0] OFS_ZERO = 16'd0;
   localparam logic [PHASE_W-1:0] OFS_0_10 = 16'd6554;
   localparam logic [PHASE_W-1:0] OFS_0_20 = 16'd13107;
   localparam logic [PHASE_W-1:0] OFS_0_25 = 16'd16384;
   localparam logic [PHASE_W-1:0] OFS_0_33 = 16'd21627;
   localparam logic [PHASE_W-1:0] OFS_0_50 = 16'd32768;
   localparam logic [PHASE_W-1:0] OFS_0_67 = 16'd43909;

   // cosine series constants, q30
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint unsigned COS_SERIES_DIV [6] = '{2, 12, 30, 56, 90, 132};
   localparam longint unsigned SIN_SERIES_DIV [6] = '{6, 20, 42, 72, 110, 156};
   localparam longint COS_ONE_Q14 = 64'sd16384;

   typedef enum logic [1:0] {
      PAL_BLUE      = 2'd0,
      PAL_SUNSET    = 2'd1,
      PAL_RED       = 2'd2,
      PAL_SYNTHWAVE = 2'd3
   } palette_type;

   typedef struct packed {
      logic [ITER_W-1:0] sample_iter_0;
      logic [ITER_W-1:0] sample_iter_1;
      logic [ITER_W-1:0] sample_iter_2;
      logic [ITER_W-1:0] sample_iter_3;
   } req_data_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rsp_data_type;

   typedef struct packed {
      logic [CNT_W-1:0]   valid_count;
      logic [PHASE_W-1:0] phase;
   } phase_type;

   typedef struct packed {
      logic               enable;
      logic [PHASE_W-1:0] offset;
   } lane_cfg_type;

   // per channel palette setting: amplitude on or off and phase offset
   function automatic lane_cfg_type lane_cfg(input palette_type pal, input logic [1:0] ch);
      lane_cfg_type cfg;
      cfg.enable = 1'b1;
      cfg.offset = OFS_ZERO;
      case (pal)
         PAL_BLUE: begin
            if (ch == CH_GREEN) cfg.offset = OFS_0_10;
            else if (ch == CH_BLUE) cfg.offset = OFS_0_20;
         end
         PAL_SUNSET: begin
            if (ch == CH_GREEN) cfg.offset = OFS_0_33;
            else if (ch == CH_BLUE) cfg.offset = OFS_0_67;
         end
         PAL_RED: begin
            cfg.enable = (ch == CH_RED);
         end
         PAL_SYNTHWAVE: begin
            if (ch == CH_RED) cfg.offset = OFS_0_50;
            else if (ch == CH_GREEN) cfg.offset = OFS_0_20;
            else cfg.offset = OFS_0_25;
         end
         default: begin
            cfg.enable = 1'b0;
         end
      endcase
      return cfg;
   endfunction

   // cosine of a 32-bit turn fraction, 14 fraction bits, elaboration only
   function automatic logic signed [COS_W-1:0] cos_from_turn(input longint unsigned u);
      longint unsigned quad;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      longint          mag;
      logic            odd;
      quad = (u >> 30) & 64'd3;
      r    = u & (ONE_Q30 - 64'd1);
      x    = (r * PI_Q30) >> 31;
      odd  = (quad == 64'd1) || (quad == 64'd3);
      x2   = (x * x) >> 30;
      term = odd ? x : ONE_Q30;
      acc  = longint'(term);
      for (int n = 0; n < 6; n++) begin
         if (odd) term = ((term * x2) >> 30) / SIN_SERIES_DIV[n];
         else term = ((term * x2) >> 30) / COS_SERIES_DIV[n];
         if ((n % 2) == 0) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      mag = (acc + 64'sd32768) >>> 16;
      if (mag > COS_ONE_Q14) mag = COS_ONE_Q14;
      if ((quad == 64'd1) || (quad == 64'd2)) mag = -mag;
      return COS_W'(mag);
   endfunction

endpackage

### design/ecc_sample_merge.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ecc_sample_merge
// four sample lanes drop saturated samples, merge into a sum and count, and
// a reciprocal divider turns the mean into a phase in 1/65536 turn
// ---------------------------------------------------------------------------
module ecc_sample_merge #(
   parameter int MaxIter = ecc_pkg::MAX_ITER
) (
   input  logic                 clock,
   input  ecc_pkg::req_data_type req_data,
   input  logic                 ss_enable,
   output ecc_pkg::phase_type   phase_out
);

   localparam logic [ecc_pkg::ITER_W-1:0] IterLimit = ecc_pkg::ITER_W'(MaxIter * 256);
   localparam int ProdW = ecc_pkg::NUM_W + ecc_pkg::QUO_W;
   localparam int QdW   = ecc_pkg::QUO_W + ecc_pkg::DIVISOR_W;

   logic [ecc_pkg::ITER_W-1:0] samp [ecc_pkg::NUM_SAMPLES];
   logic [ecc_pkg::NUM_SAMPLES-1:0] lane_ok;

   logic [ecc_pkg::SUM_W-1:0] sum_in, sum_s1_ff;
   logic [ecc_pkg::CNT_W-1:0] cnt_in, cnt_s1_ff;

   logic [ecc_pkg::QUO_W-1:0]     recip;
   logic [ecc_pkg::DIVISOR_W-1:0] divisor_in;
   logic [ProdW-1:0]              est_prod;
   logic [ecc_pkg::NUM_W-1:0]     numer_s1;

   logic [ecc_pkg::NUM_W-1:0]     numer_s2_ff, numer_s3_ff;
   logic [ecc_pkg::QUO_W-1:0]     q_est_in, q_est_s2_ff, q_est_s3_ff;
   logic [ecc_pkg::DIVISOR_W-1:0] div_s2_ff, div_s3_ff;
   logic [ecc_pkg::CNT_W-1:0]     cnt_s2_ff, cnt_s3_ff, cnt_s4_ff;
   logic [QdW-1:0]                qd_full;
   logic [ecc_pkg::NUM_W-1:0]     qd_in, qd_s3_ff;

   logic [ecc_pkg::NUM_W-1:0]     rem;
   logic [ecc_pkg::PHASE_W-1:0]   phase_in, phase_s4_ff;

   assign samp[0] = req_data.sample_iter_0;
   assign samp[1] = req_data.sample_iter_1;
   assign samp[2] = req_data.sample_iter_2;
   assign samp[3] = req_data.sample_iter_3;

   // sample lanes
   for (genvar i = 0; i < ecc_pkg::NUM_SAMPLES; i++) begin : g_lane
      if (i == 0) begin : g_first
         assign lane_ok[i] = (samp[i] != IterLimit);
      end else begin : g_rest
         assign lane_ok[i] = ss_enable && (samp[i] != IterLimit);
      end
   end

   // merge lanes into sum and valid count
   always_comb begin
      sum_in = '0;
      cnt_in = '0;
      for (int i = 0; i < ecc_pkg::NUM_SAMPLES; i++) begin
         if (lane_ok[i]) begin
            sum_in = sum_in + ecc_pkg::SUM_W'(samp[i]);
            cnt_in = cnt_in + ecc_pkg::CNT_W'(1);
         end
      end
   end

   // estimate quotient by reciprocal of 50 * count
   always_comb begin
      case (cnt_s1_ff)
         3'd1: begin
            recip      = ecc_pkg::RECIP_BY_1;
            divisor_in = ecc_pkg::DIVISOR_W'(ecc_pkg::SAMPLE_SCALE * 1);
         end
         3'd2: begin
            recip      = ecc_pkg::RECIP_BY_2;
            divisor_in = ecc_pkg::DIVISOR_W'(ecc_pkg::SAMPLE_SCALE * 2);
         end
         3'd3: begin
            recip      = ecc_pkg::RECIP_BY_3;
            divisor_in = ecc_pkg::DIVISOR_W'(ecc_pkg::SAMPLE_SCALE * 3);
         end
         3'd4: begin
            recip      = ecc_pkg::RECIP_BY_4;
            divisor_in = ecc_pkg::DIVISOR_W'(ecc_pkg::SAMPLE_SCALE * 4);
         end
         default: begin
            recip      = '0;
            divisor_in = '0;
         end
      endcase
   end

   assign numer_s1 = {sum_s1_ff, 8'd0};
   assign est_prod = ProdW'(numer_s1) * ProdW'(recip);
   assign q_est_in = est_prod[ecc_pkg::DIV_SHIFT +: ecc_pkg::QUO_W];

   // back-multiply; the estimate never exceeds the numerator
   assign qd_full = QdW'(q_est_s2_ff) * QdW'(div_s2_ff);
   assign qd_in   = qd_full[ecc_pkg::NUM_W-1:0];

   // estimate is low by at most one
   assign rem      = numer_s3_ff - qd_s3_ff;
   assign phase_in = q_est_s3_ff[ecc_pkg::PHASE_W-1:0]
                     + ecc_pkg::PHASE_W'(rem >= ecc_pkg::NUM_W'(div_s3_ff));

   always_ff @(posedge clock) begin
      sum_s1_ff   <= sum_in;
      cnt_s1_ff   <= cnt_in;

      numer_s2_ff <= numer_s1;
      q_est_s2_ff <= q_est_in;
      div_s2_ff   <= divisor_in;
      cnt_s2_ff   <= cnt_s1_ff;

      numer_s3_ff <= numer_s2_ff;
      q_est_s3_ff <= q_est_s2_ff;
      div_s3_ff   <= div_s2_ff;
      qd_s3_ff    <= qd_in;
      cnt_s3_ff   <= cnt_s2_ff;

      phase_s4_ff <= phase_in;
      cnt_s4_ff   <= cnt_s3_ff;
   end

   assign phase_out.valid_count = cnt_s4_ff;
   assign phase_out.phase       = phase_s4_ff;

endmodule

### design/ecc_channel_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ecc_channel_lane
// one color channel: palette offset, cosine table lookup, brightness scale
// ---------------------------------------------------------------------------
module ecc_channel_lane #(
   parameter int CosTableDepth = ecc_pkg::COS_TABLE_DEPTH
) (
   input  logic                          clock,
   input  ecc_pkg::phase_type            phase_in,
   input  ecc_pkg::lane_cfg_type         cfg,
   output logic [ecc_pkg::COLOR_W-1:0]   color
);

   localparam int IdxW   = $clog2(CosTableDepth);
   localparam int IdxPW  = ecc_pkg::PHASE_W + IdxW + 1;
   localparam int ScaleW = ecc_pkg::CNT_W + ecc_pkg::COLOR_W;
   localparam int LevelW = ecc_pkg::COS_W;
   localparam int MulW   = LevelW + ScaleW;

   logic signed [ecc_pkg::COS_W-1:0] cos_rom [CosTableDepth];

   logic [ecc_pkg::PHASE_W-1:0] ph;
   logic [IdxPW-1:0]            idx_prod;
   logic [IdxW-1:0]             idx_s5_ff;
   logic [ecc_pkg::CNT_W-1:0]   cnt_s5_ff, cnt_s6_ff;
   logic                        en_s5_ff, en_s6_ff;
   logic signed [ecc_pkg::COS_W-1:0] cos_s6_ff;

   logic signed [LevelW:0]      level_wide;
   logic [LevelW-1:0]           level;
   logic [ScaleW-1:0]           scale;
   logic [MulW-1:0]             bright;
   logic [MulW-18:0]            shade;
   logic [ecc_pkg::COLOR_W-1:0] color_in, color_s7_ff;

   // cosine table, one entry per index, built at elaboration
   for (genvar k = 0; k < CosTableDepth; k++) begin : g_rom
      localparam longint unsigned Turn = (longint'(k) << 32) / CosTableDepth;
      assign cos_rom[k] = ecc_pkg::cos_from_turn(Turn);
   end

   assign ph       = phase_in.phase + cfg.offset;
   assign idx_prod = IdxPW'(ph) * IdxPW'(CosTableDepth);

   // (1 + cos) * count * 255 / 8, in q14
   assign level_wide = (LevelW + 1)'(ecc_pkg::COS_ONE_Q14) + (LevelW + 1)'(cos_s6_ff);
   assign level      = level_wide[LevelW-1:0];
   assign scale      = ScaleW'(cnt_s6_ff) * ScaleW'(255);
   assign bright     = MulW'(level) * MulW'(scale);
   assign shade      = bright[MulW-1:17];

   always_comb begin
      if (!en_s6_ff) color_in = '0;
      else if (shade > (MulW - 17)'(255)) color_in = 8'd255;
      else color_in = shade[ecc_pkg::COLOR_W-1:0];
   end

   always_ff @(posedge clock) begin
      idx_s5_ff   <= idx_prod[ecc_pkg::PHASE_W +: IdxW];
      cnt_s5_ff   <= phase_in.valid_count;
      en_s5_ff    <= cfg.enable;

      cos_s6_ff   <= cos_rom[idx_s5_ff];
      cnt_s6_ff   <= cnt_s5_ff;
      en_s6_ff    <= en_s5_ff;

      color_s7_ff <= color_in;
   end

   assign color = color_s7_ff;

endmodule

### design/escape_count_cosine_colorizer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// escape_count_cosine_colorizer_core
// turns per-pixel smooth escape counts into an 8-bit rgb cosine palette color
// ---------------------------------------------------------------------------
// Takes one pixel transaction per clock while req_stall is low and returns
// its color through the sample merge (drop saturated samples, sum, then a
// reciprocal-multiply divide by 50 * count) and then the three color
// lanes (offset and table index, registered cosine table read, scale by
// count * 255 / 8). Results land in a 16-entry output queue, so the input
// keeps taking pixels while a finished color waits; req_stall rises only
// when the queue plus the pipeline hold 16 pixels. Each lane carries its own
// CosTableDepth-entry cosine table built at elaboration. Write palette_select
// and supersample_enable only while no pixel is in flight.
module escape_count_cosine_colorizer_core #(
   parameter int MaxIter       = ecc_pkg::MAX_ITER,
   parameter int CosTableDepth = ecc_pkg::COS_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  ecc_pkg::req_data_type               req_data,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ecc_pkg::rsp_data_type               rsp_data,

   input  logic                                csr_wr_en,
   input  logic [ecc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ecc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

`include "escape_count_cosine_colorizer_core_macros.svh"

   ecc_pkg::palette_type palette_ff, palette_in;
   logic                 ss_enable_ff, ss_enable_in;

   logic req_accept, rsp_accept, fifo_wr;

   logic [ecc_pkg::PIPE_LATENCY-1:0] pipe_vld_ff, pipe_vld_in;

   ecc_pkg::phase_type    phase;
   ecc_pkg::lane_cfg_type lane_cfg [ecc_pkg::NUM_CHANNELS];
   logic [ecc_pkg::COLOR_W-1:0] lane_color [ecc_pkg::NUM_CHANNELS];
   ecc_pkg::rsp_data_type fifo_wdata;

   ecc_pkg::rsp_data_type fifo_mem_ff [ecc_pkg::FIFO_DEPTH];
   logic [ecc_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ecc_pkg::FIFO_CNT_W-1:0] fill_ff, fill_in, credit_ff, credit_in;

   // configuration registers
   always_comb begin
      palette_in   = palette_ff;
      ss_enable_in = ss_enable_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ecc_pkg::CSR_PALETTE_SELECT:     palette_in = ecc_pkg::palette_type'(csr_wdata);
            ecc_pkg::CSR_SUPERSAMPLE_ENABLE: ss_enable_in = csr_wdata[0];
            default: begin
               palette_in   = palette_ff;
               ss_enable_in = ss_enable_ff;
            end
         endcase
      end
   end

   // credit covers pixels in the pipeline plus queued colors
   assign req_stall  = (credit_ff == ecc_pkg::FIFO_CNT_W'(ecc_pkg::FIFO_DEPTH));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (fill_ff != '0);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign fifo_wr    = pipe_vld_ff[ecc_pkg::PIPE_LATENCY-1];

   assign pipe_vld_in = {pipe_vld_ff[ecc_pkg::PIPE_LATENCY-2:0], req_accept};

   ecc_sample_merge #(
      .MaxIter (MaxIter)
   ) u_merge (
      .clock     (clock),
      .req_data  (req_data),
      .ss_enable (ss_enable_ff),
      .phase_out (phase)
   );

   for (genvar ch = 0; ch < ecc_pkg::NUM_CHANNELS; ch++) begin : g_chan
      assign lane_cfg[ch] = ecc_pkg::lane_cfg(palette_ff, 2'(ch));

      ecc_channel_lane #(
         .CosTableDepth (CosTableDepth)
      ) u_lane (
         .clock    (clock),
         .phase_in (phase),
         .cfg      (lane_cfg[ch]),
         .color    (lane_color[ch])
      );
   end

   assign fifo_wdata.red   = lane_color[ecc_pkg::CH_RED];
   assign fifo_wdata.green = lane_color[ecc_pkg::CH_GREEN];
   assign fifo_wdata.blue  = lane_color[ecc_pkg::CH_BLUE];

   // output queue
   always_comb begin
      wr_ptr_in = wr_ptr_ff + ecc_pkg::FIFO_PTR_W'(fifo_wr);
      rd_ptr_in = rd_ptr_ff + ecc_pkg::FIFO_PTR_W'(rsp_accept);
      fill_in   = fill_ff + ecc_pkg::FIFO_CNT_W'(fifo_wr)
                  - ecc_pkg::FIFO_CNT_W'(rsp_accept);
      credit_in = credit_ff + ecc_pkg::FIFO_CNT_W'(req_accept)
                  - ecc_pkg::FIFO_CNT_W'(rsp_accept);
   end

   assign rsp_data = fifo_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (fifo_wr) begin
         fifo_mem_ff[wr_ptr_ff] <= fifo_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff   <= ecc_pkg::PAL_BLUE;
         ss_enable_ff <= 1'b0;
         pipe_vld_ff  <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         credit_ff    <= '0;
      end else begin
         palette_ff   <= palette_in;
         ss_enable_ff <= ss_enable_in;
         pipe_vld_ff  <= pipe_vld_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         credit_ff    <= credit_in;
      end
   end

   `ECC_ASSERT_ALWAYS(a_credit_tracks_flight, ($countones(pipe_vld_ff) + 32'(fill_ff)) == 32'(credit_ff), "credit count out of step with pipeline and queue")
   `ECC_ASSERT_ALWAYS(a_credit_bound, credit_ff <= ecc_pkg::FIFO_CNT_W'(ecc_pkg::FIFO_DEPTH), "credit count above queue depth")
   `ECC_ASSERT_IMPLY(a_no_queue_overflow, fifo_wr, (fill_ff != ecc_pkg::FIFO_CNT_W'(ecc_pkg::FIFO_DEPTH)) || rsp_accept, "color written into a full queue")
   `ECC_ASSERT_NEXT(a_accept_enters_pipe, req_accept, pipe_vld_ff[0], "accepted pixel missing from pipeline")

endmodule
